[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/sidam_pkg.sv]
// package for the symbol id address map unit
// holds opcodes, status codes, address window and queue word type
`default_nettype none
package sidam_pkg;
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0, OP_LOAD = 3'd1, OP_FUNC_A2I = 3'd2, OP_FUNC_I2A = 3'd3,
    OP_MOVE_A2I = 3'd4, OP_MOVE_I2A = 3'd5, OP_NOP6 = 3'd6, OP_NOP7 = 3'd7
  } op_e;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_NOT_READY = 3'd2, ST_BAD_ENTRY = 3'd3,
    ST_UNSORTED = 3'd4, ST_COUNTS = 3'd5, ST_OVERFLOW = 3'd6
  } status_e;
  typedef enum logic [1:0] {PH_LOADING = 2'd0, PH_READY = 2'd1, PH_FAILED = 2'd2} phase_e;
  localparam logic [31:0] ADDR_LOW = 32'h8000_0000;
  localparam logic [31:0] ADDR_END = 32'h8180_0000;
  localparam int unsigned CNT_W = 13;
  // one classified word passed from front to back
  typedef struct packed {
    op_e         op;
    logic [31:0] symbol_id;
    logic [31:0] code_address;
  } cmd_t;
endpackage
`default_nettype wire

[hw/rtl/sidam_queue.sv]
// two-entry queue between front and back
// uses sidam_pkg::cmd_t
`default_nettype none
module sidam_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sidam_pkg::cmd_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output sidam_pkg::cmd_t       pop_data_o,
  output logic                  empty_o
);
  sidam_pkg::cmd_t mem_q [2];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q ^ (push_i & ~full_o);
    rd_d = rd_q ^ (pop_i & ~empty_o);
    cnt_d = cnt_q + {1'b0, push_i & ~full_o} - {1'b0, pop_i & ~empty_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `ASSERT_NEXT(a_full_hold, clk_i, rst_ni, full_o && !pop_i, full_o)
endmodule
`default_nettype wire

[hw/rtl/sidam_engine.sv]
// back part: table memory, load checks, linear scan and binary search
// uses sidam_pkg
`default_nettype none
module sidam_engine #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [sidam_pkg::CNT_W-1:0] cfg_data_i,
  input  wire logic                       cmd_valid_i,
  input  wire sidam_pkg::cmd_t            cmd_i,
  output logic                            cmd_ready_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic [31:0]                     res_value_o,
  output logic [2:0]                      res_status_o,
  output logic                            res_table_ready_o
);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1) + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_OUT} state_e;

  logic [63:0] mem [MAX_ENTRIES];
  logic [63:0] rdata_q;

  state_e state_q;
  logic [sidam_pkg::CNT_W-1:0] fcnt_q, mcnt_q;
  logic [CW-1:0] loaded_q, lo_q, hi_q, idx_q, base_q;
  sidam_pkg::phase_e phase_q;
  logic [31:0] prev_q;
  sidam_pkg::cmd_t cur_q;
  logic [31:0] val_q;
  logic [2:0] st_q;
  logic out_v_q;
  logic [CW-1:0] total, fext, mext, mid, k;
  logic counts_ok, scan;
  logic [31:0] key;

  assign fext = CW'(fcnt_q);
  assign mext = CW'(mcnt_q);
  assign total = fext + mext;
  assign counts_ok = (fext <= MAXC) && (mext <= MAXC) && (total <= MAXC);
  assign scan = (cur_q.op == sidam_pkg::OP_FUNC_A2I) || (cur_q.op == sidam_pkg::OP_MOVE_A2I);
  assign key = scan ? cur_q.code_address : cur_q.symbol_id;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign k = base_q + (scan ? idx_q : mid);

  assign cmd_ready_o = (state_q == S_IDLE) && !out_v_q && !cfg_we_i;
  assign res_valid_o = out_v_q;
  assign res_value_o = val_q;
  assign res_status_o = st_q;
  assign res_table_ready_o = (phase_q == sidam_pkg::PH_READY);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[k[AW-1:0]];
    if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o && cmd_i.op == sidam_pkg::OP_LOAD &&
        phase_q == sidam_pkg::PH_LOADING && counts_ok && loaded_q < total &&
        cmd_i.symbol_id != 32'd0 && cmd_i.code_address >= sidam_pkg::ADDR_LOW &&
        cmd_i.code_address < sidam_pkg::ADDR_END &&
        !(loaded_q != '0 && loaded_q != fext && cmd_i.symbol_id <= prev_q))
      mem[loaded_q[AW-1:0]] <= {cmd_i.symbol_id, cmd_i.code_address};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fcnt_q <= '0;
      mcnt_q <= '0;
      loaded_q <= '0;
      phase_q <= sidam_pkg::PH_READY;
      prev_q <= '0;
      out_v_q <= 1'b0;
      val_q <= '0;
      st_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      idx_q <= '0;
      base_q <= '0;
      cur_q <= '0;
    end else begin
      if (out_v_q && res_ready_i) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        // a register write also clears the table
        logic [CW-1:0] nf, nm;
        nf = cfg_idx_i ? fext : CW'(cfg_data_i);
        nm = cfg_idx_i ? CW'(cfg_data_i) : mext;
        if (cfg_idx_i) mcnt_q <= cfg_data_i; else fcnt_q <= cfg_data_i;
        loaded_q <= '0;
        prev_q <= '0;
        phase_q <= (nf == '0 && nm == '0) ? sidam_pkg::PH_READY : sidam_pkg::PH_LOADING;
      end else begin
        case (state_q)
          S_IDLE: if (cmd_valid_i && cmd_ready_o) begin
            cur_q <= cmd_i;
            val_q <= '0;
            st_q <= sidam_pkg::ST_OK;
            case (cmd_i.op)
              sidam_pkg::OP_CLEAR: begin
                loaded_q <= '0;
                prev_q <= '0;
                phase_q <= (counts_ok && total == '0) ? sidam_pkg::PH_READY
                                                      : sidam_pkg::PH_LOADING;
                out_v_q <= 1'b1;
              end
              sidam_pkg::OP_LOAD: begin
                out_v_q <= 1'b1;
                if (phase_q == sidam_pkg::PH_FAILED) st_q <= sidam_pkg::ST_NOT_READY;
                else if (phase_q == sidam_pkg::PH_READY) begin
                  phase_q <= sidam_pkg::PH_FAILED;
                  st_q <= sidam_pkg::ST_OVERFLOW;
                end else if (!counts_ok) begin
                  phase_q <= sidam_pkg::PH_FAILED;
                  st_q <= sidam_pkg::ST_COUNTS;
                end else if (loaded_q >= total) begin
                  phase_q <= sidam_pkg::PH_FAILED;
                  st_q <= sidam_pkg::ST_OVERFLOW;
                end else if (cmd_i.symbol_id == 32'd0 ||
                             cmd_i.code_address < sidam_pkg::ADDR_LOW ||
                             cmd_i.code_address >= sidam_pkg::ADDR_END) begin
                  phase_q <= sidam_pkg::PH_FAILED;
                  st_q <= sidam_pkg::ST_BAD_ENTRY;
                end else if (loaded_q != '0 && loaded_q != fext &&
                             cmd_i.symbol_id <= prev_q) begin
                  phase_q <= sidam_pkg::PH_FAILED;
                  st_q <= sidam_pkg::ST_UNSORTED;
                end else begin
                  loaded_q <= loaded_q + 1'b1;
                  prev_q <= cmd_i.symbol_id;
                  if (loaded_q + 1'b1 == total) phase_q <= sidam_pkg::PH_READY;
                end
              end
              sidam_pkg::OP_FUNC_A2I, sidam_pkg::OP_FUNC_I2A,
              sidam_pkg::OP_MOVE_A2I, sidam_pkg::OP_MOVE_I2A: begin
                if (phase_q != sidam_pkg::PH_READY) begin
                  st_q <= sidam_pkg::ST_NOT_READY;
                  out_v_q <= 1'b1;
                end else begin
                  base_q <= (cmd_i.op >= sidam_pkg::OP_MOVE_A2I) ? fext : '0;
                  hi_q <= (cmd_i.op >= sidam_pkg::OP_MOVE_A2I) ? mext : fext;
                  lo_q <= '0;
                  idx_q <= '0;
                  state_q <= S_RD;
                end
              end
              default: out_v_q <= 1'b1;
            endcase
          end
          S_RD: begin
            // hi_q is the count for a scan, the upper bound for a search
            if (key == 32'd0 || (scan ? idx_q >= hi_q : lo_q >= hi_q) || k >= MAXC) begin
              st_q <= sidam_pkg::ST_NOT_FOUND;
              state_q <= S_OUT;
            end else state_q <= S_CHK;
          end
          S_CHK: begin
            if (scan) begin
              if (rdata_q[31:0] == key) begin
                val_q <= rdata_q[63:32];
                state_q <= S_OUT;
              end else begin
                idx_q <= idx_q + 1'b1;
                state_q <= S_RD;
              end
            end else begin
              if (rdata_q[63:32] == key) begin
                val_q <= rdata_q[31:0];
                state_q <= S_OUT;
              end else begin
                if (rdata_q[63:32] < key) lo_q <= mid + 1'b1;
                else hi_q <= mid;
                state_q <= S_RD;
              end
            end
          end
          S_OUT: begin
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_loaded_bound, clk_i, rst_ni, 1'b1, loaded_q <= MAXC)
  `ASSERT_IMPL(a_ready_full, clk_i, rst_ni,
               phase_q == sidam_pkg::PH_READY && state_q == S_IDLE, loaded_q == total)
  `ASSERT_IMPL(a_busy_no_out, clk_i, rst_ni, state_q != S_IDLE, !out_v_q)
endmodule
`default_nettype wire

[hw/rtl/symbol_id_address_map_unit.sv]
// top level of the symbol id address map unit
// front accept stage, sidam_queue and sidam_engine; uses sidam_pkg
//
// usage: s_axis carries one command word per handshake (opcode, symbol id,
// code address); m_axis returns one result word per command (value,
// status, table ready flag). two config registers (function section size
// at index 0, mmove section size at index 1) are written through cfg_we_i/
// cfg_idx_i/cfg_data_i; the user writes them only while the block is idle,
// which the block does not enforce; a write also clears the table.
// path of a command to its result: clear, load, unused opcodes and lookups
// on a table that is not ready pass through the queue and then the engine,
// which registers the result. an address lookup scans the section one
// entry at a time, each a read state and a check state; an id lookup is a
// binary search of at most log2(count)+1 probes, each also a read state and
// a check state, as the entry memory has a single read port.
// throughput: one command at a time; the front queue takes up to two
// words while the engine is busy.
// reset: counts are zero, table is empty and ready, queue empty; the
// entry memory has no reset and its read data is only used where written.
// a stalled m_axis_tready holds the result word and the engine waits.
`default_nettype none
module symbol_id_address_map_unit #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], symbol_id[34:3], code_address[66:35], zero pad
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // value[31:0], status[34:32], table_ready[35], zero pad
  output logic [39:0]      m_axis_tdata
);
  sidam_pkg::cmd_t in_word, q_word;
  logic q_full, q_empty, eng_ready;
  logic [31:0] r_value;
  logic [2:0] r_status;
  logic r_ready;

  // front: unpack and classify into a queue word
  assign in_word.op = sidam_pkg::op_e'(s_axis_tdata[2:0]);
  assign in_word.symbol_id = s_axis_tdata[34:3];
  assign in_word.code_address = s_axis_tdata[66:35];
  assign s_axis_tready = !q_full;

  sidam_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid), .push_data_i(in_word), .full_o(q_full),
    .pop_i(eng_ready && !q_empty), .pop_data_o(q_word), .empty_o(q_empty)
  );

  sidam_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(!q_empty), .cmd_i(q_word), .cmd_ready_o(eng_ready),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_value_o(r_value), .res_status_o(r_status), .res_table_ready_o(r_ready)
  );

  // table ready reflects phase after this command, held while the word waits
  assign m_axis_tdata = {4'd0, r_ready, r_status, r_value};
endmodule
`default_nettype wire
